>>> hw/rtl/pfc_pkg.sv
// Shared constants, types and state encodings of the prime filter.
package pfc_pkg;

    localparam int MAX_ITEMS = 128;

    localparam int VALUE_W = 32;
    localparam int PRIME_W = 31;
    localparam int POS_W   = 7;
    localparam int TOTAL_W = 8;

    // Trial divisors never exceed 46341, so 16 bits hold a divisor and a remainder.
    localparam int DIV_W   = 16;
    localparam int SQ_W    = 32;
    localparam int BIT_W   = 5;

    localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(MAX_ITEMS - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(MAX_ITEMS);
    localparam logic [BIT_W-1:0]   BITS_LAST = BIT_W'(PRIME_W - 1);

    localparam logic KIND_PRIME = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_PRIME,
        S_COUNT
    } t_ctl_state;

    typedef enum logic [2:0] {
        T_IDLE,
        T_CHECK,
        T_DIV,
        T_NEXT,
        T_PRIME,
        T_COMPOSITE
    } t_trial_state;

    typedef struct packed {
        logic               start;
        logic [PRIME_W-1:0] value;
    } t_trial_req;

    typedef struct packed {
        logic done;
        logic is_prime;
    } t_trial_sts;

endpackage

>>> hw/rtl/pfc_if.sv
// Handshake channels of the prime filter: input items and result items.
interface pfc_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pfc_pkg::VALUE_W-1:0] value;
    logic                               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface pfc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [pfc_pkg::PRIME_W-1:0] prime_value;
    logic [pfc_pkg::POS_W-1:0]   position;
    logic [pfc_pkg::TOTAL_W-1:0] prime_total;
    logic                        end_of_results;

    modport source (output valid, output kind, output prime_value, output position,
                    output prime_total, output end_of_results, input ready);
    modport sink   (input valid, input kind, input prime_value, input position,
                    input prime_total, input end_of_results, output ready);
endinterface

>>> hw/rtl/pfc_trial.sv
// Trial division unit: bit-serial remainder for each divisor while d*d <= n.
module pfc_trial (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfc_pkg::t_trial_req i_req,
    output pfc_pkg::t_trial_sts o_sts
);

    pfc_pkg::t_trial_state r_state, n_state;

    logic [pfc_pkg::PRIME_W-1:0] r_n;
    logic [pfc_pkg::DIV_W-1:0]   r_d;
    logic [pfc_pkg::SQ_W-1:0]    r_sq;
    logic [pfc_pkg::PRIME_W-1:0] r_shift;
    logic [pfc_pkg::DIV_W-1:0]   r_rem;
    logic [pfc_pkg::BIT_W-1:0]   r_bit;

    logic [pfc_pkg::DIV_W:0]     w_trial;
    logic [pfc_pkg::DIV_W:0]     w_diff;
    logic [pfc_pkg::DIV_W-1:0]   n_rem;
    logic                        w_fits;

    // One restoring step: bring in the next bit of n, subtract d if it fits.
    always_comb begin
        w_trial = {r_rem, r_shift[pfc_pkg::PRIME_W-1]};
        w_diff  = w_trial - {1'b0, r_d};
        if (w_trial >= {1'b0, r_d}) begin
            n_rem = w_diff[pfc_pkg::DIV_W-1:0];
        end else begin
            n_rem = w_trial[pfc_pkg::DIV_W-1:0];
        end
    end

    assign w_fits = r_sq <= {1'b0, r_n};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfc_pkg::T_IDLE: begin
                if (i_req.start) n_state = pfc_pkg::T_CHECK;
            end
            pfc_pkg::T_CHECK: begin
                n_state = w_fits ? pfc_pkg::T_DIV : pfc_pkg::T_PRIME;
            end
            pfc_pkg::T_DIV: begin
                if (r_bit == pfc_pkg::BITS_LAST) n_state = pfc_pkg::T_NEXT;
            end
            pfc_pkg::T_NEXT: begin
                n_state = (r_rem == '0) ? pfc_pkg::T_COMPOSITE : pfc_pkg::T_CHECK;
            end
            pfc_pkg::T_PRIME:     n_state = pfc_pkg::T_IDLE;
            pfc_pkg::T_COMPOSITE: n_state = pfc_pkg::T_IDLE;
            default:              n_state = pfc_pkg::T_IDLE;
        endcase
    end

    always_comb begin
        o_sts.done     = (r_state == pfc_pkg::T_PRIME) || (r_state == pfc_pkg::T_COMPOSITE);
        o_sts.is_prime = (r_state == pfc_pkg::T_PRIME);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfc_pkg::T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pfc_pkg::T_IDLE: begin
                if (i_req.start) begin
                    r_n  <= i_req.value;
                    r_d  <= pfc_pkg::DIV_W'(2);
                    r_sq <= pfc_pkg::SQ_W'(4);
                end
            end
            pfc_pkg::T_CHECK: begin
                // The top bit alone is always below d, so it is the first remainder.
                r_rem   <= {{(pfc_pkg::DIV_W-1){1'b0}}, r_n[pfc_pkg::PRIME_W-1]};
                r_shift <= r_n << 1;
                r_bit   <= pfc_pkg::BIT_W'(1);
            end
            pfc_pkg::T_DIV: begin
                r_rem   <= n_rem;
                r_shift <= r_shift << 1;
                r_bit   <= r_bit + pfc_pkg::BIT_W'(1);
            end
            pfc_pkg::T_NEXT: begin
                // (d+1)^2 = d^2 + 2d + 1
                r_sq <= r_sq + pfc_pkg::SQ_W'({r_d, 1'b1});
                r_d  <= r_d + pfc_pkg::DIV_W'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hw/rtl/prime_filter_with_count.sv
// Prime filter top level: run control, position and prime count, result register.
//
// Each item is tested by trial division with divisors 2, 3, ... while d*d does not
// exceed the value; the remainder for each divisor is formed one bit per cycle.
// Values below 2 skip the divider. Items are taken one at a time; the next item is
// accepted as soon as the results of the current one are in the output register,
// even while the last of them still waits to be taken. A prime gives a prime
// report with its position in the run; the last item of a run also gives a count
// report, after which position and count restart. Position saturates at
// MAX_ITEMS-1 and the count at MAX_ITEMS.
module prime_filter_with_count (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfc_in_if.sink     i_in,
    pfc_out_if.source  o_out
);

    pfc_pkg::t_ctl_state r_state, n_state;

    logic [pfc_pkg::PRIME_W-1:0] r_value;
    logic                        r_last;
    logic [pfc_pkg::POS_W-1:0]   r_pos;
    logic [pfc_pkg::POS_W-1:0]   r_pos_item;
    logic [pfc_pkg::TOTAL_W-1:0] r_primes;

    logic                        r_out_valid;
    logic                        r_out_kind;
    logic [pfc_pkg::PRIME_W-1:0] r_out_value;
    logic [pfc_pkg::POS_W-1:0]   r_out_pos;
    logic [pfc_pkg::TOTAL_W-1:0] r_out_total;
    logic                        r_out_end;

    logic                        w_accept;
    logic                        w_candidate;
    logic                        w_slot_free;
    logic                        w_in_ready;
    logic                        w_load_prime;
    logic                        w_load_count;

    pfc_pkg::t_trial_req         w_req;
    pfc_pkg::t_trial_sts         w_sts;

    pfc_trial u_trial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_sts   (w_sts)
    );

    assign w_accept    = i_in.valid && w_in_ready;
    assign w_candidate = !i_in.value[pfc_pkg::VALUE_W-1] && (i_in.value[pfc_pkg::VALUE_W-2:1] != '0);
    assign w_slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfc_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_candidate) begin
                        n_state = pfc_pkg::S_WAIT;
                    end else if (i_in.last) begin
                        n_state = pfc_pkg::S_COUNT;
                    end
                end
            end
            pfc_pkg::S_WAIT: begin
                if (w_sts.done) begin
                    if (w_sts.is_prime) begin
                        n_state = pfc_pkg::S_PRIME;
                    end else if (r_last) begin
                        n_state = pfc_pkg::S_COUNT;
                    end else begin
                        n_state = pfc_pkg::S_IDLE;
                    end
                end
            end
            pfc_pkg::S_PRIME: begin
                if (w_slot_free) n_state = r_last ? pfc_pkg::S_COUNT : pfc_pkg::S_IDLE;
            end
            pfc_pkg::S_COUNT: begin
                if (w_slot_free) n_state = pfc_pkg::S_IDLE;
            end
            default: n_state = pfc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready   = (r_state == pfc_pkg::S_IDLE);
        w_load_prime = (r_state == pfc_pkg::S_PRIME) && w_slot_free;
        w_load_count = (r_state == pfc_pkg::S_COUNT) && w_slot_free;
        w_req.start  = w_accept && w_candidate;
        w_req.value  = i_in.value[pfc_pkg::PRIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfc_pkg::S_IDLE;
            r_pos       <= '0;
            r_primes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                if (i_in.last) begin
                    r_pos <= '0;
                end else if (r_pos != pfc_pkg::POS_LAST) begin
                    r_pos <= r_pos + pfc_pkg::POS_W'(1);
                end
            end

            if (w_load_count) begin
                r_primes <= '0;
            end else if ((r_state == pfc_pkg::S_WAIT) && w_sts.done && w_sts.is_prime
                         && (r_primes != pfc_pkg::TOTAL_MAX)) begin
                r_primes <= r_primes + pfc_pkg::TOTAL_W'(1);
            end

            if (w_load_prime || w_load_count) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value    <= i_in.value[pfc_pkg::PRIME_W-1:0];
            r_last     <= i_in.last;
            r_pos_item <= r_pos;
        end

        if (w_load_prime) begin
            r_out_kind  <= pfc_pkg::KIND_PRIME;
            r_out_value <= r_value;
            r_out_pos   <= r_pos_item;
            r_out_total <= '0;
            r_out_end   <= !r_last;
        end else if (w_load_count) begin
            r_out_kind  <= pfc_pkg::KIND_COUNT;
            r_out_value <= '0;
            r_out_pos   <= '0;
            r_out_total <= r_primes;
            r_out_end   <= 1'b1;
        end
    end

    assign i_in.ready           = w_in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out_kind;
    assign o_out.prime_value    = r_out_value;
    assign o_out.position       = r_out_pos;
    assign o_out.prime_total    = r_out_total;
    assign o_out.end_of_results = r_out_end;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == pfc_pkg::S_WAIT))
        else $error("trial unit finished while no item was waiting");

    a_count_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == pfc_pkg::KIND_COUNT))
        |-> (r_out_end && (r_out_total <= pfc_pkg::TOTAL_MAX)))
        else $error("count report malformed");

    a_prime_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == pfc_pkg::KIND_PRIME))
        |-> ((r_out_value >= pfc_pkg::PRIME_W'(2)) && (r_out_total == '0)))
        else $error("prime report carries a value below two");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_kind)))
        else $error("pending result dropped or changed");
`endif

endmodule

>>> tb/prime_filter_with_count_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the prime filter: directed table followed by random runs.
module prime_filter_with_count_tb;

    localparam int RANDOM_ITEMS     = 80;
    localparam int HOLD_OFF_CYCLES  = 500;
    localparam int DRAIN_CYCLES     = 200;
    // The largest 31-bit prime keeps the block busy for the longest time.
    localparam int IDLE_LIMIT       = 6_000_000;

    typedef struct packed {
        logic                        kind;
        logic [pfc_pkg::PRIME_W-1:0] prime_value;
        logic [pfc_pkg::POS_W-1:0]   position;
        logic [pfc_pkg::TOTAL_W-1:0] prime_total;
        logic                        end_of_results;
    } t_report;

    // typed = 1: the expected reports are written in the row; else the predictor decides.
    typedef struct packed {
        logic [pfc_pkg::VALUE_W-1:0] value;
        logic                        last;
        logic                        typed;
        logic [1:0]                  n_exp;
        t_report                     first;
        t_report                     second;
    } t_row;

    localparam t_report NONE = '0;
    localparam int N_DIRECTED = 20;

    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{32'd2,          1'b0, 1'b1, 2'd1,
          '{pfc_pkg::KIND_PRIME, 31'd2, 7'd0, 8'd0, 1'b1}, NONE},
        '{32'h8000_0000,  1'b0, 1'b1, 2'd0, NONE, NONE},
        '{32'd0,          1'b0, 1'b1, 2'd0, NONE, NONE},
        '{32'd1,          1'b0, 1'b1, 2'd0, NONE, NONE},
        '{32'hFFFF_FFFF,  1'b0, 1'b1, 2'd0, NONE, NONE},
        '{32'd3,          1'b0, 1'b0, 2'd0, NONE, NONE},
        '{32'd4,          1'b0, 1'b0, 2'd0, NONE, NONE},
        '{32'h7FFF_FFFE,  1'b0, 1'b1, 2'd0, NONE, NONE},
        '{32'h7FFF_FFFF,  1'b1, 1'b1, 2'd2,
          '{pfc_pkg::KIND_PRIME, 31'h7FFF_FFFF, 7'd8, 8'd0, 1'b0},
          '{pfc_pkg::KIND_COUNT, 31'd0, 7'd0, 8'd3, 1'b1}},
        '{32'd7,          1'b1, 1'b1, 2'd2,
          '{pfc_pkg::KIND_PRIME, 31'd7, 7'd0, 8'd0, 1'b0},
          '{pfc_pkg::KIND_COUNT, 31'd0, 7'd0, 8'd1, 1'b1}},
        '{32'd9,          1'b1, 1'b1, 2'd1,
          '{pfc_pkg::KIND_COUNT, 31'd0, 7'd0, 8'd0, 1'b1}, NONE},
        '{32'd25,         1'b0, 1'b0, 2'd0, NONE, NONE},
        '{32'd65537,      1'b0, 1'b0, 2'd0, NONE, NONE},
        '{32'd121,        1'b0, 1'b0, 2'd0, NONE, NONE},
        '{32'd1,          1'b1, 1'b0, 2'd0, NONE, NONE},
        '{32'hFFFF_FFF9,  1'b1, 1'b1, 2'd1,
          '{pfc_pkg::KIND_COUNT, 31'd0, 7'd0, 8'd0, 1'b1}, NONE},
        '{32'h7FFF_FFFD,  1'b0, 1'b1, 2'd0, NONE, NONE},
        '{32'h5555_5555,  1'b0, 1'b0, 2'd0, NONE, NONE},
        '{32'h2AAA_AAAA,  1'b0, 1'b0, 2'd0, NONE, NONE},
        '{32'd97,         1'b1, 1'b0, 2'd0, NONE, NONE}
    };

    logic i_clk;
    logic i_rst_n;

    pfc_in_if  in_if ();
    pfc_out_if out_if ();

    prime_filter_with_count DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_report expected_reports [$];
    int      run_position;
    int      run_primes;
    int      mismatches = 0;
    int      burst_left;
    int      idle_cycles = 0;
    bit      hold_off_req;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Offers one item, waits for it to be taken and records the reports it must cause.
    task automatic send_item(input t_row row);
        int              gap;
        bit              is_prime;
        longint unsigned d;
        t_report         predicted [$];

        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;

        in_if.valid <= 1'b1;
        in_if.value <= row.value;
        in_if.last  <= row.last;
        forever begin
            @(posedge i_clk);
            if (in_if.valid && in_if.ready) break;
        end

        is_prime = 1'b0;
        if (!row.value[pfc_pkg::VALUE_W-1] && row.value >= 2) begin
            is_prime = 1'b1;
            for (d = 2; d * d <= row.value; d++) begin
                if (row.value % d == 0) begin
                    is_prime = 1'b0;
                    break;
                end
            end
        end
        if (is_prime) begin
            predicted.push_back('{pfc_pkg::KIND_PRIME, row.value[pfc_pkg::PRIME_W-1:0],
                                  pfc_pkg::POS_W'(run_position), pfc_pkg::TOTAL_W'(0),
                                  !row.last});
            if (run_primes < pfc_pkg::MAX_ITEMS) run_primes++;
        end
        if (row.last) begin
            predicted.push_back('{pfc_pkg::KIND_COUNT, pfc_pkg::PRIME_W'(0), pfc_pkg::POS_W'(0),
                                  pfc_pkg::TOTAL_W'(run_primes), 1'b1});
            run_position = 0;
            run_primes   = 0;
        end else if (run_position < pfc_pkg::MAX_ITEMS - 1) begin
            run_position++;
        end

        if (row.typed) begin
            if (row.n_exp > 0) expected_reports.push_back(row.first);
            if (row.n_exp > 1) expected_reports.push_back(row.second);
        end else begin
            foreach (predicted[i]) expected_reports.push_back(predicted[i]);
        end
    endtask

    initial begin : receiver
        int stall_mode;
        int stall_left;
        bit hold_done;

        stall_mode   = 0;
        stall_left   = 0;
        hold_done    = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 80);
            end
            stall_left--;
            case (stall_mode)
                2: begin
                    out_if.ready <= 1'($urandom_range(0, 1));
                end
                3: begin
                    out_if.ready <= ($urandom_range(0, 5) == 0);
                end
                default: begin
                    out_if.ready <= 1'b1;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_report want;

        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result item: kind %0d, prime_value %0d, prime_total %0d",
                       out_if.kind, out_if.prime_value, out_if.prime_total);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                if (out_if.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
                    mismatches++;
                end
                if (out_if.prime_value !== want.prime_value) begin
                    $error("prime_value: expected %0d, got %0d",
                           want.prime_value, out_if.prime_value);
                    mismatches++;
                end
                if (out_if.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, out_if.position);
                    mismatches++;
                end
                if (out_if.prime_total !== want.prime_total) begin
                    $error("prime_total: expected %0d, got %0d",
                           want.prime_total, out_if.prime_total);
                    mismatches++;
                end
                if (out_if.end_of_results !== want.end_of_results) begin
                    $error("end_of_results: expected %0d, got %0d",
                           want.end_of_results, out_if.end_of_results);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int          sel;
        int          run_left;
        int          factor;
        logic [31:0] v;
        t_row        row;

        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        in_if.last   = 1'b0;
        run_position = 0;
        run_primes   = 0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        run_left     = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) send_item(DIRECTED_ROWS[i]);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (run_left == 0) run_left = $urandom_range(1, 12);
            run_left--;
            if (k == 20) hold_off_req = 1'b1;

            sel = $urandom_range(0, 19);
            if (sel < 9) begin
                v = $urandom_range(0, 3000);
            end else if (sel < 11) begin
                v = {1'b1, 31'($urandom)};
            end else if (sel < 13) begin
                v = $urandom_range(3000, 70000);
            end else if (sel < 17) begin
                // Large values get a small factor so that the divider finishes quickly.
                v = {1'b0, 31'($urandom)};
                case ($urandom_range(0, 3))
                    0: factor = 2;
                    1: factor = 3;
                    2: factor = 5;
                    default: factor = 7;
                endcase
                v = v - v % factor;
            end else begin
                case ($urandom_range(0, 4))
                    0: v = 32'd0;
                    1: v = 32'd1;
                    2: v = 32'd2;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h7FFF_FFFE;
                endcase
            end

            row       = '0;
            row.value = v;
            row.last  = (run_left == 0) || (k == RANDOM_ITEMS - 1);
            send_item(row);
        end
        in_if.valid <= 1'b0;

        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> prime_filter_with_count.f
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_if.sv
hw/rtl/pfc_trial.sv
hw/rtl/prime_filter_with_count.sv
tb/prime_filter_with_count_tb.sv
